[src/retry_message_slot_table_core_macros.svh]
// Assertion macros shared by the slot table RTL.
`ifndef RETRY_MESSAGE_SLOT_TABLE_CORE_MACROS_SVH
`define RETRY_MESSAGE_SLOT_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, held off while reset is asserted.
`define RMST_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define RMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RMST_ASSERT(lbl, clk, rstn, prop, msg)
`define RMST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/rmst_pkg.sv]
package rmst_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int TIME_W = 32;
    localparam int ATT_W  = 8;

    localparam logic [ATT_W-1:0] ATTEMPT_MAX = 8'd255;

    typedef enum logic [2:0] {
        OP_ENQUEUE      = 3'd0,
        OP_ACQUIRE      = 3'd1,
        OP_MARK_SENDING = 3'd2,
        OP_MARK_SENT    = 3'd3,
        OP_MARK_FAILED  = 3'd4,
        OP_READ         = 3'd5,
        OP_CLEAR        = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_SENDING = 2'd1,
        ST_SENT    = 2'd2,
        ST_FAILED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0]       message;
        status_t           status;
        logic [ATT_W-1:0]  attempts;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] created;
        logic [TIME_W-1:0] updated;
    } entry_t;

    // One write and one read per cycle toward the slot memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] slot;
        entry_t           entry;
        logic [CNT_W-1:0] depth;
        logic [CNT_W-1:0] pending;
    } res_t;

    function automatic logic is_waiting(input status_t s);
        is_waiting = (s == ST_PENDING) || (s == ST_FAILED);
    endfunction

    // Wrap-safe: due when now - due is non-negative as a signed 32-bit value.
    function automatic logic is_due(input logic [TIME_W-1:0] now_t,
                                    input logic [TIME_W-1:0] due_t);
        logic [TIME_W-1:0] diff;
        diff   = now_t - due_t;
        is_due = ~diff[TIME_W-1];
    endfunction

endpackage

[src/rmst_table_ram.sv]
module rmst_table_ram (
    input  logic              clk,
    input  rmst_pkg::ram_req_t req,
    output rmst_pkg::entry_t   rdata_reg
);
    import rmst_pkg::*;

    entry_t mem [SLOTS];

    // Read-first on a same-address write, registered read; contents have no reset.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

endmodule

[src/rmst_seq.sv]
`include "retry_message_slot_table_core_macros.svh"

module rmst_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [2:0]                 op,
    input  logic [31:0]                now_ms,
    input  logic [rmst_pkg::IDX_W-1:0] slot_index,
    input  logic [31:0]                retry_delay,
    input  logic [31:0]                message_handle,
    output rmst_pkg::ram_req_t         ram_req,
    input  rmst_pkg::entry_t           ram_rdata,
    output logic                       res_valid,
    input  logic                       res_take,
    output rmst_pkg::res_t             res
);
    import rmst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  used_cnt_reg, used_cnt_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;
    logic [2:0]        op_reg, op_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] delay_reg, delay_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              ok_reg, ok_next;
    entry_t            ent_reg, ent_next;

    logic              accept;
    logic [CNT_W-1:0]  scan_nxt;
    entry_t            mod_ent;
    entry_t            new_ent;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign scan_nxt  = {1'b0, idx_reg} + CNT_W'(1);
    assign res_valid = (state_reg == S_FIN);

    always_comb
    begin
        new_ent.message  = message_handle;
        new_ent.status   = ST_PENDING;
        new_ent.attempts = '0;
        new_ent.due      = now_ms;
        new_ent.created  = now_ms;
        new_ent.updated  = now_ms;
    end

    // Apply the mark operation to the entry just read.
    always_comb
    begin
        mod_ent = ram_rdata;
        case (op_reg)
            OP_MARK_SENDING:
            begin
                mod_ent.status  = ST_SENDING;
                mod_ent.updated = now_reg;
            end
            OP_MARK_SENT:
            begin
                mod_ent.status  = ST_SENT;
                mod_ent.updated = now_reg;
            end
            OP_MARK_FAILED:
            begin
                mod_ent.status  = ST_FAILED;
                if (ram_rdata.attempts != ATTEMPT_MAX)
                begin
                    mod_ent.attempts = ram_rdata.attempts + ATT_W'(1);
                end
                mod_ent.due     = now_reg + delay_reg;
                mod_ent.updated = now_reg;
            end
            default:
            begin
                mod_ent = ram_rdata;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        used_cnt_next = used_cnt_reg;
        pend_cnt_next = pend_cnt_reg;
        op_next       = op_reg;
        now_next      = now_reg;
        delay_next    = delay_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        ent_next      = ent_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = used_cnt_reg[IDX_W-1:0];
        ram_req.wdata = new_ent;
        ram_req.raddr = slot_index;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op;
                    now_next   = now_ms;
                    delay_next = retry_delay;
                    ok_next    = 1'b0;
                    idx_next   = '0;
                    ent_next   = '0;
                    state_next = S_FIN;
                    case (op)
                        OP_ENQUEUE:
                        begin
                            if (used_cnt_reg < CNT_W'(SLOTS))
                            begin
                                ram_req.we    = 1'b1;
                                ok_next       = 1'b1;
                                idx_next      = used_cnt_reg[IDX_W-1:0];
                                ent_next      = new_ent;
                                used_cnt_next = used_cnt_reg + CNT_W'(1);
                                pend_cnt_next = pend_cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_ACQUIRE:
                        begin
                            if (used_cnt_reg != '0)
                            begin
                                ram_req.raddr = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_MARK_SENDING, OP_MARK_SENT, OP_MARK_FAILED, OP_READ:
                        begin
                            if ({1'b0, slot_index} < used_cnt_reg)
                            begin
                                idx_next   = slot_index;
                                state_next = S_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            ok_next       = 1'b1;
                            used_cnt_next = '0;
                            pend_cnt_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                // Write back the modified entry and adjust the waiting count.
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = mod_ent;
                ok_next       = 1'b1;
                ent_next      = mod_ent;
                pend_cnt_next = pend_cnt_reg
                              - CNT_W'(is_waiting(ram_rdata.status))
                              + CNT_W'(is_waiting(mod_ent.status));
                state_next    = S_FIN;
            end
            S_SCAN:
            begin
                ram_req.raddr = scan_nxt[IDX_W-1:0];
                if (is_waiting(ram_rdata.status) && is_due(now_reg, ram_rdata.due))
                begin
                    ok_next    = 1'b1;
                    ent_next   = ram_rdata;
                    state_next = S_FIN;
                end
                else if (scan_nxt < used_cnt_reg)
                begin
                    idx_next = scan_nxt[IDX_W-1:0];
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.ok      = ok_reg;
        res.slot    = idx_reg;
        res.entry   = ent_reg;
        res.depth   = used_cnt_reg;
        res.pending = pend_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_cnt_reg <= '0;
            pend_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            used_cnt_reg <= used_cnt_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        now_reg   <= now_next;
        delay_reg <= delay_next;
        idx_reg   <= idx_next;
        ok_reg    <= ok_next;
        ent_reg   <= ent_next;
    end

    `RMST_ASSERT(a_clear_empties, clk, rst_n,
        accept && (op == OP_CLEAR) |=> (used_cnt_reg == '0) && (pend_cnt_reg == '0),
        "clear did not empty the table")
    `RMST_ASSERT(a_scan_in_use, clk, rst_n,
        (state_reg == S_SCAN) |-> ({1'b0, idx_reg} < used_cnt_reg),
        "scan reached a slot beyond the used count")
    `RMST_ASSERT_ALWAYS(a_counts_bounded, clk,
        !rst_n || ((pend_cnt_reg <= used_cnt_reg) && (used_cnt_reg <= CNT_W'(SLOTS))),
        "slot counts out of range")

endmodule

[src/retry_message_slot_table_core.sv]
// Enqueue, clear, unknown op and out-of-range index go from idle straight to the finish state;
// mark and read pass a read state that writes the entry back; acquire scans the used slots,
// 1 to 16 examined, one slot per cycle from the slot memory's read port.
// A new request is taken only once the previous result has moved to the output register.
// Reset clears the used and waiting counts and the handshake state; slot memory is not
// cleared and needs no clearing pass.
`include "retry_message_slot_table_core_macros.svh"

module retry_message_slot_table_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [2:0]                 op,
    input  logic [31:0]                now_ms,
    input  logic [rmst_pkg::IDX_W-1:0] slot_index,
    input  logic [31:0]                retry_delay,
    input  logic [31:0]                message_handle,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic                       ok,
    output logic [rmst_pkg::IDX_W-1:0] found_slot,
    output logic [1:0]                 slot_status,
    output logic [7:0]                 attempts,
    output logic [31:0]                due_time,
    output logic [31:0]                created_time,
    output logic [31:0]                updated_time,
    output logic [31:0]                slot_message,
    output logic [rmst_pkg::CNT_W-1:0] table_depth,
    output logic [rmst_pkg::CNT_W-1:0] pending_total
);
    import rmst_pkg::*;

    ram_req_t ram_req;
    entry_t   ram_rdata;
    res_t     res;
    logic     res_valid;
    logic     res_take;

    logic     rsp_valid_reg, rsp_valid_next;
    res_t     rsp_reg;

    // Slot memory: one entry per slot, read data in the cycle after the address.
    rmst_table_ram u_ram (
        .clk       (clk),
        .req       (ram_req),
        .rdata_reg (ram_rdata)
    );

    // Sequencer: takes a request, reads/modifies/writes the slot memory, scans on acquire.
    rmst_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .op             (op),
        .now_ms         (now_ms),
        .slot_index     (slot_index),
        .retry_delay    (retry_delay),
        .message_handle (message_handle),
        .ram_req        (ram_req),
        .ram_rdata      (ram_rdata),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res)
    );

    // Output register: load a finished result when the register is empty or draining,
    // so the sequencer can return to idle while its response waits in the register.
    assign res_take = res_valid && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the payload until the response is taken.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign ok            = rsp_reg.ok;
    assign found_slot    = rsp_reg.slot;
    assign slot_status   = rsp_reg.entry.status;
    assign attempts      = rsp_reg.entry.attempts;
    assign due_time      = rsp_reg.entry.due;
    assign created_time  = rsp_reg.entry.created;
    assign updated_time  = rsp_reg.entry.updated;
    assign slot_message  = rsp_reg.entry.message;
    assign table_depth   = rsp_reg.depth;
    assign pending_total = rsp_reg.pending;

    `RMST_ASSERT(a_rsp_counts, clk, rst_n,
        rsp_valid_reg |-> (rsp_reg.pending <= rsp_reg.depth),
        "response reports more waiting slots than slots in use")

endmodule
